FILE: design/was_pkg.sv
// Shared types, constants and the control store of the weekly alarm scheduler.
`default_nettype none

package was_pkg;

  // Table and field sizes.
  localparam int unsigned ALARM_SLOTS_DEF = 8;
  localparam int unsigned COUNT_W         = 4;
  localparam int unsigned SLOT_W          = 3;
  localparam int unsigned DIST_W          = 14;
  localparam int unsigned DUE_BITS        = 8;

  // Calendar constants.
  localparam int unsigned MIN_PER_HOUR = 60;
  localparam int unsigned DAY_MINUTES  = 24 * 60;
  localparam int unsigned HOUR_MAX     = 23;
  localparam int unsigned MINUTE_MAX   = 59;
  localparam int unsigned DAY_BITS     = 7;
  localparam int unsigned SEARCH_DAYS  = 8;

  // Request operation codes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Register indexes of the register port.
  localparam logic REG_ALARM_COUNT = 1'b0;

  // One stored alarm slot.
  typedef struct packed {
    logic                en;
    logic [4:0]          hour;
    logic [5:0]          minute;
    logic [DAY_BITS-1:0] days;
  } entry_t;

  // Microcode addresses.
  typedef logic [2:0] upc_t;

  localparam upc_t UPC_WAIT     = 3'd0;
  localparam upc_t UPC_DISPATCH = 3'd1;
  localparam upc_t UPC_CHECK    = 3'd2;
  localparam upc_t UPC_EVAL     = 3'd3;
  localparam upc_t UPC_UPDATE   = 3'd4;
  localparam upc_t UPC_WRITE    = 3'd5;
  localparam upc_t UPC_EMIT     = 3'd6;

  // Jump conditions of a control word.
  typedef enum logic [2:0] {
    JMP_ALWAYS,
    JMP_NO_REQ,
    JMP_IS_WRITE,
    JMP_SCAN_DONE,
    JMP_OUT_BUSY
  } jump_e;

  // One control word: datapath strobes, then the branch.
  typedef struct packed {
    logic  accept;
    logic  start;
    logic  rd_issue;
    logic  eval;
    logic  update;
    logic  write;
    logic  emit;
    jump_e jump;
    upc_t  target;
    upc_t  next;
  } ctrl_t;

  // Conditions that the datapath reports to the sequencer.
  typedef struct packed {
    logic in_valid;
    logic is_write;
    logic scan_done;
    logic out_busy;
  } stat_t;

  // Control store. A taken jump goes to target, otherwise to next.
  function automatic ctrl_t ucode_rom(input upc_t upc);
    ctrl_t w;
    w = '0;
    w.jump   = JMP_ALWAYS;
    w.target = UPC_WAIT;
    w.next   = UPC_WAIT;
    case (upc)
      UPC_WAIT: begin
        w.accept = 1'b1;
        w.jump   = JMP_NO_REQ;
        w.target = UPC_WAIT;
        w.next   = UPC_DISPATCH;
      end
      UPC_DISPATCH: begin
        w.start  = 1'b1;
        w.jump   = JMP_IS_WRITE;
        w.target = UPC_WRITE;
        w.next   = UPC_CHECK;
      end
      UPC_CHECK: begin
        w.rd_issue = 1'b1;
        w.jump     = JMP_SCAN_DONE;
        w.target   = UPC_EMIT;
        w.next     = UPC_EVAL;
      end
      UPC_EVAL: begin
        w.eval   = 1'b1;
        w.jump   = JMP_ALWAYS;
        w.target = UPC_UPDATE;
        w.next   = UPC_UPDATE;
      end
      UPC_UPDATE: begin
        w.update = 1'b1;
        w.jump   = JMP_ALWAYS;
        w.target = UPC_CHECK;
        w.next   = UPC_CHECK;
      end
      UPC_WRITE: begin
        w.write  = 1'b1;
        w.jump   = JMP_ALWAYS;
        w.target = UPC_EMIT;
        w.next   = UPC_EMIT;
      end
      UPC_EMIT: begin
        w.emit   = 1'b1;
        w.jump   = JMP_OUT_BUSY;
        w.target = UPC_EMIT;
        w.next   = UPC_WAIT;
      end
      default: begin
        w.jump   = JMP_ALWAYS;
        w.target = UPC_WAIT;
        w.next   = UPC_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: design/was_sequencer.sv
// Microprogram sequencer: step counter, control store lookup and branching.
`default_nettype none

module was_sequencer
  import was_pkg::*;
(
  input  wire   clk_i,
  input  wire   rst_ni,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  upc_t  upc_q, upc_d;
  ctrl_t word;
  logic  take;

  // Fetch the current control word and resolve its branch.
  always_comb begin
    word = ucode_rom(upc_q);
    case (word.jump)
      JMP_ALWAYS:    take = 1'b1;
      JMP_NO_REQ:    take = !stat_i.in_valid;
      JMP_IS_WRITE:  take = stat_i.is_write;
      JMP_SCAN_DONE: take = stat_i.scan_done;
      JMP_OUT_BUSY:  take = stat_i.out_busy;
      default:       take = 1'b1;
    endcase
    upc_d = take ? word.target : word.next;
  end

  // Step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UPC_WAIT;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign ctrl_o = word;

endmodule

`default_nettype wire

FILE: design/was_table.sv
// Alarm slot memory with one write port, one registered read port and valid bits.
`default_nettype none

module was_table
  import was_pkg::*;
#(
  parameter int unsigned ALARM_SLOTS = ALARM_SLOTS_DEF,
  parameter int unsigned AW          = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           wr_en_i,
  input  wire  [AW-1:0] wr_addr_i,
  input  entry_t        wr_data_i,
  input  wire           rd_en_i,
  input  wire  [AW-1:0] rd_addr_i,
  output entry_t        rd_data_o
);

  entry_t                 mem [ALARM_SLOTS];
  logic [ALARM_SLOTS-1:0] vld_q;
  entry_t                 rd_q;
  logic                   rd_vld_q;

  // Storage array; entries never written read as disabled through the valid bits.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  // Per-entry valid bits and the valid bit of the read data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

`default_nettype wire

FILE: design/was_datapath.sv
// Datapath: request latch, slot scan, distance search, best-slot tracking and result register.
`default_nettype none

module was_datapath
  import was_pkg::*;
#(
  parameter int unsigned ALARM_SLOTS = ALARM_SLOTS_DEF,
  parameter int unsigned AW          = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1,
  parameter int unsigned CNT_W       = $clog2(ALARM_SLOTS + 1)
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  ctrl_t               ctrl_i,
  output stat_t               stat_o,
  input  wire  [COUNT_W-1:0]  alarm_count_i,
  // Request channel payload.
  input  wire                 in_valid_i,
  input  wire                 op_i,
  input  wire  [2:0]          slot_i,
  input  wire                 enabled_i,
  input  wire  [7:0]          alarm_hour_i,
  input  wire  [7:0]          alarm_min_i,
  input  wire  [7:0]          alarm_days_i,
  input  wire  [4:0]          now_hour_i,
  input  wire  [5:0]          now_min_i,
  input  wire  [2:0]          now_wday_i,
  // Table access.
  output logic                wr_en_o,
  output logic [AW-1:0]       wr_addr_o,
  output entry_t              wr_data_o,
  output logic                rd_en_o,
  output logic [AW-1:0]       rd_addr_o,
  input  entry_t              rd_data_i,
  // Result channel.
  input  wire                 out_stall_i,
  output logic                out_valid_o,
  output logic                found_o,
  output logic [2:0]          next_slot_o,
  output logic [DIST_W-1:0]   minutes_until_o,
  output logic [DUE_BITS-1:0] due_mask_o,
  output logic                clamped_o
);

  localparam int unsigned CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  // Latched request fields.
  logic       op_q;
  logic [2:0] slot_q;
  logic       en_q;
  logic [7:0] hour_q, min_q, days_q;
  logic [4:0] now_hour_q;
  logic [5:0] now_min_q;
  logic [2:0] now_wday_q;

  // Scan state.
  logic [CNT_W-1:0]    idx_q, idx_d;
  logic                found_q, found_d;
  logic [AW-1:0]       best_idx_q, best_idx_d;
  logic [DIST_W-1:0]   best_dist_q, best_dist_d;
  logic [DUE_BITS-1:0] due_q, due_d;
  logic                clamped_q, clamped_d;

  // Candidate of the slot being looked at.
  logic              cand_found_q, cand_found_d;
  logic [DIST_W-1:0] cand_dist_q, cand_dist_d;
  logic              cand_due_q, cand_due_d;

  // Result register.
  logic                out_valid_q;
  logic                out_found_q;
  logic [2:0]          out_slot_q;
  logic [DIST_W-1:0]   out_dist_q;
  logic [DUE_BITS-1:0] out_due_q;
  logic                out_clamped_q;

  // Search and write helpers.
  logic                    out_busy;
  logic                    load_out;
  logic                    slot_ok;
  logic                    hour_over, min_over, days_over;
  logic [10:0]             alarm_t, now_t;
  logic signed [DIST_W:0]  diff_s;
  logic signed [DIST_W:0]  day_delta [SEARCH_DAYS];
  logic [SEARCH_DAYS-1:0]  hit;
  logic [3:0]              wd_sum [SEARCH_DAYS];
  logic [2:0]              wd [SEARCH_DAYS];
  logic [DAY_BITS:0]       days_x;
  logic                    day_any;

  // Status for the sequencer.
  assign out_busy = out_valid_q && out_stall_i;
  assign stat_o.in_valid  = in_valid_i;
  assign stat_o.is_write  = (op_q == OP_WRITE);
  assign stat_o.scan_done = (CMP_W'(idx_q) >= CMP_W'(alarm_count_i)) ||
                            (32'(idx_q) >= 32'(ALARM_SLOTS));
  assign stat_o.out_busy  = out_busy;

  // Latch the request when it is taken.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept && in_valid_i) begin
      op_q       <= op_i;
      slot_q     <= slot_i;
      en_q       <= enabled_i;
      hour_q     <= alarm_hour_i;
      min_q      <= alarm_min_i;
      days_q     <= alarm_days_i;
      now_hour_q <= now_hour_i;
      now_min_q  <= now_min_i;
      now_wday_q <= now_wday_i;
    end
  end

  // Clamp a slot write and address the table.
  always_comb begin
    hour_over = hour_q > 8'(HOUR_MAX);
    min_over  = min_q > 8'(MINUTE_MAX);
    days_over = days_q[7];
    slot_ok   = 32'(slot_q) < 32'(ALARM_SLOTS);
    wr_en_o   = ctrl_i.write && slot_ok;
    wr_addr_o = AW'(slot_q);
    wr_data_o.en     = en_q;
    wr_data_o.hour   = hour_over ? 5'(HOUR_MAX) : hour_q[4:0];
    wr_data_o.minute = min_over ? 6'(MINUTE_MAX) : min_q[5:0];
    wr_data_o.days   = days_q[DAY_BITS-1:0];
    rd_en_o   = ctrl_i.rd_issue;
    rd_addr_o = idx_q[AW-1:0];
  end

  // Distance search over today and the next seven days; the earliest day that hits wins.
  always_comb begin
    alarm_t = 11'(rd_data_i.hour) * 11'(MIN_PER_HOUR) + 11'(rd_data_i.minute);
    now_t   = 11'(now_hour_q) * 11'(MIN_PER_HOUR) + 11'(now_min_q);
    diff_s  = $signed({4'b0000, alarm_t}) - $signed({4'b0000, now_t});
    day_any = (rd_data_i.days == '0);
    for (int d = 0; d < SEARCH_DAYS; d++) begin
      day_delta[d] = $signed((DIST_W + 1)'(d * DAY_MINUTES)) + diff_s;
      wd_sum[d]    = {1'b0, now_wday_q} + 4'(d);
      if (wd_sum[d] >= 4'(2 * DAY_BITS)) begin
        wd[d] = 3'(wd_sum[d] - 4'(2 * DAY_BITS));
      end else if (wd_sum[d] >= 4'(DAY_BITS)) begin
        wd[d] = 3'(wd_sum[d] - 4'(DAY_BITS));
      end else begin
        wd[d] = wd_sum[d][2:0];
      end
      hit[d] = (day_delta[d] > 0) && (day_any || rd_data_i.days[wd[d]]);
    end
    cand_dist_d = '0;
    for (int d = SEARCH_DAYS - 1; d >= 0; d--) begin
      if (hit[d]) begin
        cand_dist_d = DIST_W'(day_delta[d]);
      end
    end
    cand_found_d = rd_data_i.en && (|hit);
    // Weekday seven matches no day bit.
    days_x     = {1'b0, rd_data_i.days};
    cand_due_d = rd_data_i.en && (rd_data_i.hour == now_hour_q) &&
                 (rd_data_i.minute == now_min_q) && (day_any || days_x[now_wday_q]);
  end

  // Scan bookkeeping: clear at dispatch, fold in one slot per update step.
  always_comb begin
    idx_d       = idx_q;
    found_d     = found_q;
    best_idx_d  = best_idx_q;
    best_dist_d = best_dist_q;
    due_d       = due_q;
    clamped_d   = clamped_q;
    if (ctrl_i.start) begin
      idx_d       = '0;
      found_d     = 1'b0;
      best_idx_d  = '0;
      best_dist_d = '0;
      due_d       = '0;
      clamped_d   = 1'b0;
    end
    if (ctrl_i.update) begin
      if (cand_found_q && (!found_q || cand_dist_q < best_dist_q)) begin
        found_d     = 1'b1;
        best_idx_d  = idx_q[AW-1:0];
        best_dist_d = cand_dist_q;
      end
      if (cand_due_q && (32'(idx_q) < 32'(DUE_BITS))) begin
        due_d = due_q | (DUE_BITS'(1) << idx_q);
      end
      idx_d = idx_q + CNT_W'(1);
    end
    if (ctrl_i.write) begin
      clamped_d = hour_over || min_over || days_over;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      found_q     <= 1'b0;
      best_idx_q  <= '0;
      best_dist_q <= '0;
      due_q       <= '0;
      clamped_q   <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      found_q     <= found_d;
      best_idx_q  <= best_idx_d;
      best_dist_q <= best_dist_d;
      due_q       <= due_d;
      clamped_q   <= clamped_d;
    end
  end

  // Candidate register between search and compare.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.eval) begin
      cand_found_q <= cand_found_d;
      cand_dist_q  <= cand_dist_d;
      cand_due_q   <= cand_due_d;
    end
  end

  // Result register; loaded once the previous result has gone.
  assign load_out = ctrl_i.emit && !out_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_found_q   <= found_q;
      out_slot_q    <= 3'(best_idx_q);
      out_dist_q    <= best_dist_q;
      out_due_q     <= due_q;
      out_clamped_q <= clamped_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign found_o         = out_found_q;
  assign next_slot_o     = out_slot_q;
  assign minutes_until_o = out_dist_q;
  assign due_mask_o      = out_due_q;
  assign clamped_o       = out_clamped_q;

endmodule

`default_nettype wire

FILE: design/weekly_alarm_scheduler.sv
// Top level of the weekly alarm scheduler: register port, sequencer, table and datapath.
`default_nettype none

// A write request stores one alarm slot (hour clamped to 23, minute to 59, days to
// seven bits) and returns one result with clamped set when anything was cut. A query
// request scans slots 0 to n-1, where n is alarm_count saturated at ALARM_SLOTS, and
// returns the soonest enabled slot strictly in the future plus the mask of slots due
// this minute; the microprogram spends three steps per slot on the single table read
// port (read, search, compare). One request is in flight at a time; a new one is taken
// once the result has been placed in the output register, even while that result still
// waits. The table comes out of reset with every slot disabled, without a clearing pass.
// alarm_count is at byte address 0 of the register port; the user must write it only
// while the block is idle, and the block itself does not enforce this.

module weekly_alarm_scheduler
  import was_pkg::*;
#(
  parameter int unsigned ALARM_SLOTS = ALARM_SLOTS_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  // Register port.
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire  [2:0]          paddr,
  input  wire  [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  // Request channel.
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  wire                 op_i,
  input  wire  [2:0]          slot_i,
  input  wire                 enabled_i,
  input  wire  [7:0]          alarm_hour_i,
  input  wire  [7:0]          alarm_min_i,
  input  wire  [7:0]          alarm_days_i,
  input  wire  [4:0]          now_hour_i,
  input  wire  [5:0]          now_min_i,
  input  wire  [2:0]          now_wday_i,
  // Result channel.
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output logic                found_o,
  output logic [2:0]          next_slot_o,
  output logic [DIST_W-1:0]   minutes_until_o,
  output logic [DUE_BITS-1:0] due_mask_o,
  output logic                clamped_o
);

  localparam int unsigned AW = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;

  logic [COUNT_W-1:0] alarm_count_q;
  ctrl_t              ctrl;
  stat_t              stat;
  logic               wr_en, rd_en;
  logic [AW-1:0]      wr_addr, rd_addr;
  entry_t             wr_data, rd_data;

  // Register port: word address in paddr[2].
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alarm_count_q <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_ALARM_COUNT)) begin
      alarm_count_q <= pwdata[COUNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_ALARM_COUNT) begin
      prdata = 32'(alarm_count_q);
    end
  end

  // A request is taken only in the wait step of the microprogram.
  assign in_stall_o = !ctrl.accept;

  was_sequencer u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  was_table #(
    .ALARM_SLOTS (ALARM_SLOTS),
    .AW          (AW)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  was_datapath #(
    .ALARM_SLOTS (ALARM_SLOTS),
    .AW          (AW)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .alarm_count_i   (alarm_count_q),
    .in_valid_i      (in_valid_i),
    .op_i            (op_i),
    .slot_i          (slot_i),
    .enabled_i       (enabled_i),
    .alarm_hour_i    (alarm_hour_i),
    .alarm_min_i     (alarm_min_i),
    .alarm_days_i    (alarm_days_i),
    .now_hour_i      (now_hour_i),
    .now_min_i       (now_min_i),
    .now_wday_i      (now_wday_i),
    .wr_en_o         (wr_en),
    .wr_addr_o       (wr_addr),
    .wr_data_o       (wr_data),
    .rd_en_o         (rd_en),
    .rd_addr_o       (rd_addr),
    .rd_data_i       (rd_data),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .found_o         (found_o),
    .next_slot_o     (next_slot_o),
    .minutes_until_o (minutes_until_o),
    .due_mask_o      (due_mask_o),
    .clamped_o       (clamped_o)
  );

endmodule

`default_nettype wire

FILE: design/was_checker.sv
// Port-level checker for the weekly alarm scheduler and its bind to the top level.
`default_nettype none

module was_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_stall_o,
  input wire        out_valid_o,
  input wire        out_stall_i,
  input wire        found_o,
  input wire [2:0]  next_slot_o,
  input wire [13:0] minutes_until_o,
  input wire [7:0]  due_mask_o,
  input wire        clamped_o
);

  // After a request is taken the block is busy and stalls the next request.
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request taken on two consecutive cycles");

  // A result with nothing found carries a zero slot and distance.
  a_none_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (next_slot_o == 3'd0 && minutes_until_o == 14'd0))
    else $error("empty result carries slot or distance");

  // A found alarm lies strictly in the future and within seven days.
  a_found_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && found_o) |-> (minutes_until_o != 14'd0 && minutes_until_o <= 14'd10080))
    else $error("found alarm distance out of range");

  // A clamped write result reports no query fields.
  a_clamp_is_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && clamped_o) |-> (!found_o && due_mask_o == 8'd0))
    else $error("clamped result carries query fields");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(found_o) && $stable(next_slot_o) &&
       $stable(minutes_until_o) && $stable(due_mask_o) && $stable(clamped_o)))
    else $error("stalled result changed");

endmodule

bind weekly_alarm_scheduler was_checker u_was_checker (.*);

`default_nettype wire
